// ===== hw/rtl/pmalu_pkg.sv =====
package pmalu_pkg;

    localparam logic [4:0] MODE_PACK16    = 5'd0;
    localparam logic [4:0] MODE_PACK32    = 5'd1;
    localparam logic [4:0] MODE_PACKFIX   = 5'd2;
    localparam logic [4:0] MODE_EXPAND    = 5'd3;
    localparam logic [4:0] MODE_MERGE     = 5'd4;
    localparam logic [4:0] MODE_MUL8X16   = 5'd5;
    localparam logic [4:0] MODE_MUL8X16AU = 5'd6;
    localparam logic [4:0] MODE_MUL8X16AL = 5'd7;
    localparam logic [4:0] MODE_MUL8SUX16 = 5'd8;
    localparam logic [4:0] MODE_MUL8ULX16 = 5'd9;
    localparam logic [4:0] MODE_MULD8SUX16 = 5'd10;
    localparam logic [4:0] MODE_MULD8ULX16 = 5'd11;
    localparam logic [4:0] MODE_CMPGT16   = 5'd12;
    localparam logic [4:0] MODE_CMPGT32   = 5'd13;
    localparam logic [4:0] MODE_CMPLE16   = 5'd14;
    localparam logic [4:0] MODE_CMPLE32   = 5'd15;
    localparam logic [4:0] MODE_CMPNE16   = 5'd16;
    localparam logic [4:0] MODE_CMPNE32   = 5'd17;
    localparam logic [4:0] MODE_CMPEQ16   = 5'd18;
    localparam logic [4:0] MODE_CMPEQ32   = 5'd19;
    localparam logic [4:0] MODE_PDIST     = 5'd20;
    localparam logic [4:0] MODE_BMASK     = 5'd21;
    localparam logic [4:0] MODE_BSHUFFLE  = 5'd22;

    localparam logic [63:0] PACK32_KEEP_MASK = 64'h000000ff000000ff;

    typedef struct packed {
        logic [4:0]  mode;
        logic [63:0] src1;
        logic [63:0] src2;
        logic [63:0] acc_in;
    } t_in;

    typedef struct packed {
        logic [63:0] result;
        logic        single_result;
    } t_out;

    // unsigned byte times signed halfword, bits 23:8 rounded on bit 7
    function automatic logic [15:0] mul8x16(input logic [7:0] b8, input logic [15:0] h16);
        logic signed [24:0] p;
        p = $signed({1'b0, b8}) * $signed(h16);
        return p[23:8] + {15'd0, p[7]};
    endfunction

endpackage

// ===== hw/rtl/partitioned_media_alu_top.sv =====
// Partitioned media ALU: one operation per transaction on two 64-bit operands,
// one result per transaction. Every operation is computed by combinational lane
// logic between the input register and the result register, and a new
// transaction is accepted every cycle while the result side keeps up. The user
// must write the scale register through i_cfg_we/i_cfg_data only while the unit
// is empty; the block itself does not enforce this. The shuffle mask is set by
// bmask and used by later bshuffle transactions in order.
module partitioned_media_alu_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pmalu_pkg::t_in     i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pmalu_pkg::t_out    o_out_data,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);

    logic            r_s1_valid;
    pmalu_pkg::t_in  r_s1;
    logic            r_out_valid;
    pmalu_pkg::t_out r_out;
    logic [4:0]      r_gsr_scale;
    logic [31:0]     r_shuffle_mask;
    logic            adv_out;
    logic            adv_in;
    pmalu_pkg::t_out n_out;

    assign adv_out     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || adv_out;
    assign adv_in      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [63:0]        a;
        logic [63:0]        b;
        logic [63:0]        r;
        logic signed [31:0] t16;
        logic signed [63:0] t32;
        logic [15:0]        h;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [10:0]        sad;
        logic [3:0]         sel;
        logic [127:0]       cat;
        logic               single;
        logic               hit;
        a      = r_s1.src1;
        b      = r_s1.src2;
        r      = '0;
        single = 1'b0;
        sad    = '0;
        cat    = {b, a};
        case (r_s1.mode)
            pmalu_pkg::MODE_PACK16: begin
                single = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    h   = b[16*i +: 16];
                    t16 = $signed({{16{h[15]}}, h}) <<< r_gsr_scale[3:0];
                    t16 = t16 >>> 7;
                    if (t16 < 0) r[8*i +: 8] = 8'd0;
                    else if (t16 > 255) r[8*i +: 8] = 8'd255;
                    else r[8*i +: 8] = t16[7:0];
                end
            end
            pmalu_pkg::MODE_PACK32: begin
                r = (a << 8) & ~pmalu_pkg::PACK32_KEEP_MASK;
                for (int i = 0; i < 2; i++) begin
                    t32 = $signed({{32{b[32*i+31]}}, b[32*i +: 32]}) <<< r_gsr_scale;
                    t32 = t32 >>> 23;
                    if (t32 < 0) r[32*i +: 8] = 8'd0;
                    else if (t32 > 255) r[32*i +: 8] = 8'd255;
                    else r[32*i +: 8] = t32[7:0];
                end
            end
            pmalu_pkg::MODE_PACKFIX: begin
                single = 1'b1;
                for (int i = 0; i < 2; i++) begin
                    t32 = $signed({{32{b[32*i+31]}}, b[32*i +: 32]}) <<< r_gsr_scale;
                    t32 = t32 >>> 16;
                    if (t32 < -32768) r[16*i +: 16] = 16'h8000;
                    else if (t32 > 32767) r[16*i +: 16] = 16'h7fff;
                    else r[16*i +: 16] = t32[15:0];
                end
            end
            pmalu_pkg::MODE_EXPAND: begin
                for (int i = 0; i < 4; i++) r[16*i +: 16] = {4'd0, b[8*i +: 8], 4'd0};
            end
            pmalu_pkg::MODE_MERGE: begin
                for (int i = 0; i < 4; i++) r[16*i +: 16] = {a[8*i +: 8], b[8*i +: 8]};
            end
            pmalu_pkg::MODE_MUL8X16: begin
                for (int i = 0; i < 4; i++)
                    r[16*i +: 16] = pmalu_pkg::mul8x16(a[8*i +: 8], b[16*i +: 16]);
            end
            pmalu_pkg::MODE_MUL8X16AU: begin
                for (int i = 0; i < 4; i++)
                    r[16*i +: 16] = pmalu_pkg::mul8x16(a[8*i +: 8], b[31:16]);
            end
            pmalu_pkg::MODE_MUL8X16AL: begin
                for (int i = 0; i < 4; i++)
                    r[16*i +: 16] = pmalu_pkg::mul8x16(a[8*i +: 8], b[15:0]);
            end
            pmalu_pkg::MODE_MUL8SUX16: begin
                for (int i = 0; i < 4; i++)
                    r[16*i +: 16] = pmalu_pkg::mul8x16(a[16*i+8 +: 8], b[16*i +: 16]);
            end
            pmalu_pkg::MODE_MUL8ULX16: begin
                for (int i = 0; i < 4; i++)
                    r[16*i +: 16] = pmalu_pkg::mul8x16(a[16*i +: 8], b[16*i +: 16]);
            end
            pmalu_pkg::MODE_MULD8SUX16: begin
                for (int i = 0; i < 2; i++)
                    r[32*i+7 +: 16] = pmalu_pkg::mul8x16(a[16*i+8 +: 8], b[16*i +: 16]);
            end
            pmalu_pkg::MODE_MULD8ULX16: begin
                for (int i = 0; i < 2; i++)
                    r[32*i+7 +: 16] = pmalu_pkg::mul8x16(a[16*i +: 8], b[16*i +: 16]);
            end
            pmalu_pkg::MODE_CMPGT16, pmalu_pkg::MODE_CMPLE16,
            pmalu_pkg::MODE_CMPNE16, pmalu_pkg::MODE_CMPEQ16: begin
                // lane 0 lands in the top mask bit
                for (int i = 0; i < 4; i++) begin
                    case (r_s1.mode)
                        pmalu_pkg::MODE_CMPGT16:
                            hit = $signed(a[16*i +: 16]) > $signed(b[16*i +: 16]);
                        pmalu_pkg::MODE_CMPLE16:
                            hit = $signed(a[16*i +: 16]) <= $signed(b[16*i +: 16]);
                        pmalu_pkg::MODE_CMPNE16: hit = a[16*i +: 16] != b[16*i +: 16];
                        default:                 hit = a[16*i +: 16] == b[16*i +: 16];
                    endcase
                    r[3-i] = hit;
                end
            end
            pmalu_pkg::MODE_CMPGT32, pmalu_pkg::MODE_CMPLE32,
            pmalu_pkg::MODE_CMPNE32, pmalu_pkg::MODE_CMPEQ32: begin
                for (int i = 0; i < 2; i++) begin
                    case (r_s1.mode)
                        pmalu_pkg::MODE_CMPGT32:
                            hit = $signed(a[32*i +: 32]) > $signed(b[32*i +: 32]);
                        pmalu_pkg::MODE_CMPLE32:
                            hit = $signed(a[32*i +: 32]) <= $signed(b[32*i +: 32]);
                        pmalu_pkg::MODE_CMPNE32: hit = a[32*i +: 32] != b[32*i +: 32];
                        default:                 hit = a[32*i +: 32] == b[32*i +: 32];
                    endcase
                    r[1-i] = hit;
                end
            end
            pmalu_pkg::MODE_PDIST: begin
                for (int i = 0; i < 8; i++) begin
                    x = a[8*i +: 8];
                    y = b[8*i +: 8];
                    sad = sad + {3'd0, (x > y) ? (x - y) : (y - x)};
                end
                r = r_s1.acc_in + {53'd0, sad};
            end
            pmalu_pkg::MODE_BMASK: begin
                r = a + b;
            end
            pmalu_pkg::MODE_BSHUFFLE: begin
                // selector picks from src2:src1 as one 16-byte row
                for (int i = 0; i < 8; i++) begin
                    sel = r_shuffle_mask[4*i +: 4];
                    r[8*i +: 8] = cat[8*sel +: 8];
                end
            end
            default: begin
                r = '0;
            end
        endcase
        n_out.result        = r;
        n_out.single_result = single;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_gsr_scale    <= '0;
            r_shuffle_mask <= '0;
        end else begin
            if (adv_in) r_s1_valid <= 1'b1;
            else if (adv_out) r_s1_valid <= 1'b0;
            if (adv_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_we) r_gsr_scale <= i_cfg_data;
            if (adv_out && r_s1.mode == pmalu_pkg::MODE_BMASK)
                r_shuffle_mask <= n_out.result[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in) r_s1 <= i_in_data;
        if (adv_out) r_out <= n_out;
    end

    a_bmask_sets_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_out && r_s1.mode == pmalu_pkg::MODE_BMASK
        |=> r_shuffle_mask == r_out.result[31:0])
        else $error("shuffle mask not taken from bmask sum");

    a_single_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.single_result |-> r_out.result[63:32] == 32'd0)
        else $error("single result has upper bits set");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && r_s1_valid |=> r_s1_valid && r_out_valid)
        else $error("transaction lost under stall");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_OPS  = 500;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    pmalu_pkg::t_in     i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    pmalu_pkg::t_out    o_out_data;
    logic               i_cfg_we;
    logic [4:0]         i_cfg_data;

    partitioned_media_alu_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // scoreboard state
    logic [4:0]         scale_shadow;
    logic [31:0]        shuffle_shadow;
    pmalu_pkg::t_out    expected_q[$];
    int                 fail_count;
    int                 idle_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 recv_hold;
    bit                 sending_done;
    bit                 use_known;
    pmalu_pkg::t_out    known_out;

    typedef struct {
        pmalu_pkg::t_in  op;
        bit              has_known;
        pmalu_pkg::t_out known;
    } t_row;

    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] x,
                                                       input int k);
        return x >>> k;
    endfunction

    function automatic logic [63:0] clamp(input logic signed [63:0] v,
                                          input logic signed [63:0] lo,
                                          input logic signed [63:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] lane_mul(input logic [7:0] b8, input logic [15:0] h16);
        logic signed [31:0] prod;
        logic [15:0]        mid;
        prod = $signed({24'd0, b8}) * $signed({{16{h16[15]}}, h16});
        mid  = prod[23:8];
        if (prod[7]) mid = mid + 16'd1;
        return mid;
    endfunction

    function automatic bit lane_cmp(input int kind, input logic signed [31:0] x,
                                    input logic signed [31:0] y);
        case (kind)
            0: return x > y;
            1: return x <= y;
            2: return x != y;
            default: return x == y;
        endcase
    endfunction

    // computes the result and, for bmask, updates the shuffle mask shadow
    function automatic pmalu_pkg::t_out media_op(input pmalu_pkg::t_in op);
        pmalu_pkg::t_out     r;
        logic signed [63:0]  v;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic [15:0]         half_src;
        logic [7:0]          ax;
        logic [7:0]          bx;
        logic [3:0]          sel;
        int                  sh;
        int                  kind;
        int                  lanes;
        int                  w;
        r = '0;
        case (op.mode)
            pmalu_pkg::MODE_PACK16: begin
                r.single_result = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    v = $signed({{48{op.src2[16*i+15]}}, op.src2[16*i +: 16]});
                    v = floor_shift(v <<< scale_shadow[3:0], 7);
                    r.result[8*i +: 8] = 8'(clamp(v, 0, 255));
                end
            end
            pmalu_pkg::MODE_PACK32: begin
                r.result = (op.src1 << 8) & ~pmalu_pkg::PACK32_KEEP_MASK;
                for (int i = 0; i < 2; i++) begin
                    v = $signed({{32{op.src2[32*i+31]}}, op.src2[32*i +: 32]});
                    v = floor_shift(v <<< scale_shadow, 23);
                    r.result[32*i +: 8] = 8'(clamp(v, 0, 255));
                end
            end
            pmalu_pkg::MODE_PACKFIX: begin
                r.single_result = 1'b1;
                for (int i = 0; i < 2; i++) begin
                    v = $signed({{32{op.src2[32*i+31]}}, op.src2[32*i +: 32]});
                    v = floor_shift(v <<< scale_shadow, 16);
                    r.result[16*i +: 16] = 16'(clamp(v, -32768, 32767));
                end
            end
            pmalu_pkg::MODE_EXPAND:
                for (int i = 0; i < 4; i++)
                    r.result[16*i +: 16] = {4'd0, op.src2[8*i +: 8], 4'd0};
            pmalu_pkg::MODE_MERGE:
                for (int i = 0; i < 4; i++)
                    r.result[16*i +: 16] = {op.src1[8*i +: 8], op.src2[8*i +: 8]};
            pmalu_pkg::MODE_MUL8X16:
                for (int i = 0; i < 4; i++)
                    r.result[16*i +: 16] = lane_mul(op.src1[8*i +: 8], op.src2[16*i +: 16]);
            pmalu_pkg::MODE_MUL8X16AU, pmalu_pkg::MODE_MUL8X16AL: begin
                half_src = (op.mode == pmalu_pkg::MODE_MUL8X16AU) ? op.src2[31:16]
                                                                  : op.src2[15:0];
                for (int i = 0; i < 4; i++)
                    r.result[16*i +: 16] = lane_mul(op.src1[8*i +: 8], half_src);
            end
            pmalu_pkg::MODE_MUL8SUX16, pmalu_pkg::MODE_MUL8ULX16: begin
                sh = (op.mode == pmalu_pkg::MODE_MUL8SUX16) ? 8 : 0;
                for (int i = 0; i < 4; i++)
                    r.result[16*i +: 16] = lane_mul(op.src1[16*i+sh +: 8],
                                                    op.src2[16*i +: 16]);
            end
            pmalu_pkg::MODE_MULD8SUX16, pmalu_pkg::MODE_MULD8ULX16: begin
                sh = (op.mode == pmalu_pkg::MODE_MULD8SUX16) ? 8 : 0;
                for (int i = 0; i < 2; i++)
                    r.result[32*i+7 +: 16] = lane_mul(op.src1[16*i+sh +: 8],
                                                      op.src2[16*i +: 16]);
            end
            pmalu_pkg::MODE_CMPGT16, pmalu_pkg::MODE_CMPGT32,
            pmalu_pkg::MODE_CMPLE16, pmalu_pkg::MODE_CMPLE32,
            pmalu_pkg::MODE_CMPNE16, pmalu_pkg::MODE_CMPNE32,
            pmalu_pkg::MODE_CMPEQ16, pmalu_pkg::MODE_CMPEQ32: begin
                kind  = int'(op.mode - pmalu_pkg::MODE_CMPGT16) >> 1;
                w     = ((op.mode - pmalu_pkg::MODE_CMPGT16) & 5'd1) != 5'd0 ? 32 : 16;
                lanes = 64 / w;
                for (int i = 0; i < lanes; i++) begin
                    if (w == 32) begin
                        x = op.src1[32*i +: 32];
                        y = op.src2[32*i +: 32];
                    end else begin
                        x = $signed(op.src1[16*i +: 16]);
                        y = $signed(op.src2[16*i +: 16]);
                    end
                    if (lane_cmp(kind, x, y)) r.result[lanes-1-i] = 1'b1;
                end
            end
            pmalu_pkg::MODE_PDIST: begin
                r.result = op.acc_in;
                for (int i = 0; i < 8; i++) begin
                    ax = op.src1[8*i +: 8];
                    bx = op.src2[8*i +: 8];
                    r.result = r.result + {56'd0, ((ax > bx) ? ax - bx : bx - ax)};
                end
            end
            pmalu_pkg::MODE_BMASK: begin
                r.result = op.src1 + op.src2;
                shuffle_shadow = r.result[31:0];
            end
            pmalu_pkg::MODE_BSHUFFLE:
                for (int i = 0; i < 8; i++) begin
                    sel = shuffle_shadow[4*i +: 4];
                    r.result[8*i +: 8] = sel[3] ? op.src2[8*sel[2:0] +: 8]
                                                : op.src1[8*sel[2:0] +: 8];
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // all-zero and all-one words, lanes near the clip thresholds, and full random words
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return {4{16'($urandom_range(0, 255) << $urandom_range(0, 8))}};
            3: return {$urandom_range(0, 1) ? 32'hffff_fff0 : 32'h0,
                       32'($urandom_range(0, 1 << 20))};
            default: return rand64();
        endcase
    endfunction

    task automatic send_op(input pmalu_pkg::t_in op);
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [4:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scale_shadow = value;
    endtask

    task automatic add_row(input logic [4:0] mode, input logic [63:0] a,
                           input logic [63:0] b, input logic [63:0] acc,
                           input bit has_known, input logic [63:0] known_res,
                           input logic known_single);
        t_row row;
        row.op        = '{mode: mode, src1: a, src2: b, acc_in: acc};
        row.has_known = has_known;
        row.known     = '{result: known_res, single_result: known_single};
        directed_rows.push_back(row);
    endtask

    // predictions are recorded when the transaction is accepted
    always @(posedge i_clk) begin
        pmalu_pkg::t_out pred;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pred = media_op(i_in_data);
            if (use_known) pred = known_out;
            expected_q.push_back(pred);
        end
    end

    always @(posedge i_clk) begin
        pmalu_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", o_out_data.result);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_out_data.result !== want.result) begin
                    $error("result: expected %h actual %h", want.result, o_out_data.result);
                    fail_count++;
                end
                if (o_out_data.single_result !== want.single_result) begin
                    $error("single_result: expected %b actual %b",
                           want.single_result, o_out_data.single_result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (recv_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("partitioned_media_alu_top: mismatch");
            $finish;
        end
    end

    // long receiver hold while the sender keeps offering
    initial begin
        recv_hold = 1'b0;
        wait (sending_done == 1'b0 && i_rst_n);
        repeat (40) @(posedge i_clk);
        recv_hold = 1'b1;
        repeat (60) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin
        pmalu_pkg::t_in op;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_out_ready    = 1'b0;
        fail_count     = 0;
        idle_count     = 0;
        scale_shadow   = '0;
        shuffle_shadow = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        sending_done   = 1'b1;
        use_known      = 1'b0;
        known_out      = '0;

        add_row(pmalu_pkg::MODE_BSHUFFLE, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                64'd0, 1'b1, 64'h0000000000000000, 1'b0);
        add_row(pmalu_pkg::MODE_PACK16, 64'd0, 64'h7fff_8000_0080_ffff, 64'd0,
                1'b1, 64'h0000_0000_ff00_0100, 1'b1);
        add_row(pmalu_pkg::MODE_PACK32, 64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_8000_0000,
                64'd0, 1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_PACKFIX, 64'd0, 64'h7fff_ffff_8000_0000, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_EXPAND, 64'd0, 64'h0000_0000_ff80_01ff, 64'd0,
                1'b1, 64'h0ff0_0800_0010_0ff0, 1'b0);
        add_row(pmalu_pkg::MODE_MERGE, 64'h0000_0000_aabb_ccdd, 64'h0000_0000_1122_3344,
                64'd0, 1'b1, 64'haa11_bb22_cc33_dd44, 1'b0);
        add_row(pmalu_pkg::MODE_MUL8X16, 64'hffff_ffff, 64'h8000_7fff_0080_ffff, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_MUL8X16AU, 64'h80ff_01ff, 64'h8000_1234, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_MUL8X16AL, 64'h80ff_01ff, 64'h8000_1234, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_MUL8SUX16, '1, 64'h8000_7fff_8000_7fff, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_MUL8ULX16, '1, 64'h8000_7fff_8000_7fff, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_MULD8SUX16, '1, 64'h8000_7fff, 64'd0, 1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_MULD8ULX16, 64'h00ff_0080, 64'hffff_0101, 64'd0,
                1'b0, 64'd0, 1'b0);
        for (int m = pmalu_pkg::MODE_CMPGT16; m <= pmalu_pkg::MODE_CMPEQ32; m++)
            add_row(5'(m), 64'h8000_7fff_0001_0000, 64'h7fff_8000_0001_ffff, 64'd0,
                    1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_PDIST, '1, 64'd0, '1, 1'b1, 64'h0000_0000_0000_07f7, 1'b0);
        add_row(pmalu_pkg::MODE_BMASK, 64'hffff_ffff_ffff_ffff, 64'h89ab_cdf0, 64'd0,
                1'b0, 64'd0, 1'b0);
        add_row(pmalu_pkg::MODE_BSHUFFLE, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                64'd0, 1'b0, 64'd0, 1'b0);
        add_row(5'd31, '1, '1, '1, 1'b1, 64'd0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        recv_idle_pct = 20;
        foreach (directed_rows[k]) begin
            // rows with a typed-in result are checked against it, the rest against media_op
            use_known = directed_rows[k].has_known;
            known_out = directed_rows[k].known;
            send_op(directed_rows[k].op);
            finish_phase();
        end
        use_known = 1'b0;

        sending_done = 1'b0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 26; recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: write_scale(5'd0);
                1: write_scale(5'd31);
                2: write_scale(5'd15);
                default: write_scale(5'($urandom_range(0, 31)));
            endcase
            for (int n = 0; n < RANDOM_OPS / 6; n++) begin
                op.mode   = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(23, 31))
                                                         : 5'($urandom_range(0, 22));
                op.src1   = rand_operand();
                op.src2   = ($urandom_range(0, 4) == 0) ? op.src1 : rand_operand();
                op.acc_in = rand64();
                send_op(op);
            end
            finish_phase();
        end

        if (fail_count == 0) begin
            $display("partitioned_media_alu_top: match");
        end else begin
            $display("partitioned_media_alu_top: mismatch");
        end
        $finish;
    end
endmodule
